// ----- rtl/core/tsilp_pkg.sv -----
package tsilp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] TOKENS_NONE = 2'd0;
  localparam logic [1:0] TOKENS_ONE  = 2'd1;
  localparam logic [1:0] TOKENS_TWO  = 2'd2;
  localparam logic [1:0] TOKENS_MANY = 2'd3;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_TOO_FEW   = 3'd2,
    STATUS_TOO_MANY  = 3'd3,
    STATUS_INVALID   = 3'd4
  } status_t;

endpackage

// ----- rtl/core/two_signed_int_line_parser_core.sv -----
// A terminator byte, once accepted, loads the result registers and raises out_valid.
// Throughput: one byte per cycle, save while a terminator is held by in_stall; the per-byte
// update is one times-ten add in the accumulator of the current token.
// A terminator stalls only while the result register is still full and stalled.
// Reset (rst, synchronous, active high) clears the line state and the result valid.
module two_signed_int_line_parser_core
  import tsilp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] first_number,
  output logic signed [31:0] second_number,
  output logic [2:0]         status
);

  logic                   in_token, in_token_next;
  logic [1:0]             token_count, token_count_next;
  logic [VALUE_WIDTH-1:0] first_accum, first_accum_next;
  logic [VALUE_WIDTH-1:0] second_accum, second_accum_next;
  logic                   first_negative, first_negative_next;
  logic                   second_negative, second_negative_next;
  logic                   first_invalid, first_invalid_next;
  logic                   second_invalid, second_invalid_next;
  logic                   digit_seen, digit_seen_next;

  logic                   accept;
  logic                   is_digit;
  logic [VALUE_WIDTH-1:0] digit;
  logic [1:0]             count_upd;
  logic                   fin_first_invalid, fin_second_invalid;
  status_t                line_status;
  logic signed [VALUE_WIDTH-1:0] first_value, second_value;

  assign in_stall = out_valid && out_stall && (char_code == CH_NUL);
  assign accept   = in_valid && !in_stall;
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = VALUE_WIDTH'(char_code - CH_ZERO);

  always_comb begin
    in_token_next        = in_token;
    token_count_next     = token_count;
    first_accum_next     = first_accum;
    second_accum_next    = second_accum;
    first_negative_next  = first_negative;
    second_negative_next = second_negative;
    first_invalid_next   = first_invalid;
    second_invalid_next  = second_invalid;
    digit_seen_next      = digit_seen;
    count_upd            = token_count;

    if (char_code == CH_NUL) begin
      in_token_next        = 1'b0;
      token_count_next     = TOKENS_NONE;
      first_accum_next     = '0;
      second_accum_next    = '0;
      first_negative_next  = 1'b0;
      second_negative_next = 1'b0;
      first_invalid_next   = 1'b0;
      second_invalid_next  = 1'b0;
      digit_seen_next      = 1'b0;
    end else if (char_code == CH_SPACE) begin
      in_token_next = 1'b0;
      if (in_token && !digit_seen) begin
        if (token_count == TOKENS_ONE) first_invalid_next = 1'b1;
        if (token_count == TOKENS_TWO) second_invalid_next = 1'b1;
      end
    end else if (!in_token && (char_code == CH_MINUS || char_code == CH_PLUS)) begin
      in_token_next   = 1'b1;
      digit_seen_next = 1'b0;
      if (token_count != TOKENS_MANY) count_upd = token_count + 2'd1;
      token_count_next = count_upd;
      if (char_code == CH_MINUS) begin
        if (count_upd == TOKENS_ONE) first_negative_next = 1'b1;
        if (count_upd == TOKENS_TWO) second_negative_next = 1'b1;
      end
    end else begin
      if (!in_token) begin
        in_token_next   = 1'b1;
        digit_seen_next = 1'b0;
        if (token_count != TOKENS_MANY) count_upd = token_count + 2'd1;
        token_count_next = count_upd;
      end
      if (is_digit) begin
        digit_seen_next = 1'b1;
        if (count_upd == TOKENS_ONE)
          first_accum_next = VALUE_WIDTH'((first_accum << 3) + (first_accum << 1) + digit);
        if (count_upd == TOKENS_TWO)
          second_accum_next = VALUE_WIDTH'((second_accum << 3) + (second_accum << 1) + digit);
      end else begin
        if (count_upd == TOKENS_ONE) first_invalid_next = 1'b1;
        if (count_upd == TOKENS_TWO) second_invalid_next = 1'b1;
      end
    end
  end

  // terminator closes the open token first
  always_comb begin
    fin_first_invalid  = first_invalid;
    fin_second_invalid = second_invalid;
    if (in_token && !digit_seen) begin
      if (token_count == TOKENS_ONE) fin_first_invalid = 1'b1;
      if (token_count == TOKENS_TWO) fin_second_invalid = 1'b1;
    end
    case (token_count)
      TOKENS_NONE: line_status = STATUS_EMPTY;
      TOKENS_ONE:  line_status = STATUS_TOO_FEW;
      TOKENS_MANY: line_status = STATUS_TOO_MANY;
      default:     line_status = (fin_first_invalid || fin_second_invalid) ?
                                 STATUS_INVALID : STATUS_OK;
    endcase
    first_value  = first_negative ? signed'(-first_accum) : signed'(first_accum);
    second_value = second_negative ? signed'(-second_accum) : signed'(second_accum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token        <= 1'b0;
      token_count     <= TOKENS_NONE;
      first_accum     <= '0;
      second_accum    <= '0;
      first_negative  <= 1'b0;
      second_negative <= 1'b0;
      first_invalid   <= 1'b0;
      second_invalid  <= 1'b0;
      digit_seen      <= 1'b0;
    end else if (accept) begin
      in_token        <= in_token_next;
      token_count     <= token_count_next;
      first_accum     <= first_accum_next;
      second_accum    <= second_accum_next;
      first_negative  <= first_negative_next;
      second_negative <= second_negative_next;
      first_invalid   <= first_invalid_next;
      second_invalid  <= second_invalid_next;
      digit_seen      <= digit_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && char_code == CH_NUL) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && char_code == CH_NUL) begin
      status <= line_status;
      if (line_status == STATUS_OK) begin
        first_number  <= 32'(first_value);
        second_number <= 32'(second_value);
      end else begin
        first_number  <= '0;
        second_number <= '0;
      end
    end
  end

endmodule
